### rtl/osrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrs_pkg
// shared types and codes for the rank/select block: request modes, result
// status codes, controller states and the controller/datapath interface
// ----------------------------------------------------------------------------
package osrs_pkg;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_RANK   = 2'd2,
      MODE_SELECT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RSTEP = 5'b00010,
      ST_RCMP  = 5'b00100,
      ST_SWAIT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam int unsigned RANK_W  = 11;
   localparam int unsigned VALUE_W = 32;

   typedef struct packed {
      logic start;
      logic clear;
      logic append;
      logic sel_read;
      logic sel_miss;
      logic rank_read;
      logic rank_update;
      logic sel_latch;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic pos_ok;
      logic range_ok;
      logic hit;
   } sts_type;

endpackage
`default_nettype wire

### rtl/osrs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrs_ctrl
// sequencer for the rank/select block: accepts a request, steps the
// midpoint search or the select read, and hands the result to the output
// register
// ----------------------------------------------------------------------------
module osrs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [1:0]       req_mode,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire osrs_pkg::sts_type sts,
   output      osrs_pkg::cmd_type cmd
);

   osrs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == osrs_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         osrs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               unique case (osrs_pkg::mode_type'(req_mode))
                  osrs_pkg::MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = osrs_pkg::ST_DONE;
                  end
                  osrs_pkg::MODE_APPEND: begin
                     cmd.append = 1'b1;
                     state_in   = osrs_pkg::ST_DONE;
                  end
                  osrs_pkg::MODE_RANK: begin
                     state_in = osrs_pkg::ST_RSTEP;
                  end
                  osrs_pkg::MODE_SELECT: begin
                     if (sts.pos_ok) begin
                        cmd.sel_read = 1'b1;
                        state_in     = osrs_pkg::ST_SWAIT;
                     end else begin
                        cmd.sel_miss = 1'b1;
                        state_in     = osrs_pkg::ST_DONE;
                     end
                  end
                  default: state_in = osrs_pkg::ST_DONE;
               endcase
            end
         end
         osrs_pkg::ST_RSTEP: begin
            if (sts.range_ok) begin
               cmd.rank_read = 1'b1;
               state_in      = osrs_pkg::ST_RCMP;
            end else begin
               state_in = osrs_pkg::ST_DONE;
            end
         end
         osrs_pkg::ST_RCMP: begin
            cmd.rank_update = 1'b1;
            state_in        = sts.hit ? osrs_pkg::ST_DONE : osrs_pkg::ST_RSTEP;
         end
         osrs_pkg::ST_SWAIT: begin
            cmd.sel_latch = 1'b1;
            state_in      = osrs_pkg::ST_DONE;
         end
         osrs_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = osrs_pkg::ST_IDLE;
            end
         end
         default: state_in = osrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osrs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### rtl/osrs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrs_dp
// datapath for the rank/select block: value table, entry count, midpoint
// search range, rank accumulator and the result output register
// ----------------------------------------------------------------------------
module osrs_dp #(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire osrs_pkg::cmd_type         cmd,
   output      osrs_pkg::sts_type         sts,
   input  wire logic signed [31:0]        req_item_value,
   input  wire logic [9:0]                req_position,
   output      logic [1:0]                rsp_status,
   output      logic [10:0]               rsp_rank_count,
   output      logic signed [31:0]        rsp_selected_value
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned PW = CW + 10;

   logic signed [31:0] mem [CAPACITY];

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      lo_ff, end_ff, mid_ff, acc_ff;
   logic [CW-1:0]      mid_c;
   logic [1:0]         status_ff;
   logic signed [31:0] query_ff, rd_ff, sel_ff;
   logic [AW-1:0]      rd_addr;
   logic               full;
   logic               do_write;

   assign full     = (count_ff == CW'(CAPACITY));
   assign do_write = cmd.append && !full;
   assign mid_c    = lo_ff + ((end_ff - lo_ff - CW'(1)) >> 1);
   assign rd_addr  = cmd.sel_read ? AW'(req_position) : AW'(mid_c);

   assign sts.pos_ok   = PW'(req_position) < PW'(count_ff);
   assign sts.range_ok = lo_ff < end_ff;
   assign sts.hit      = (rd_ff == query_ff);

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[AW'(count_ff)] <= req_item_value;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (do_write) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         query_ff <= req_item_value;
         lo_ff    <= '0;
         end_ff   <= count_ff;
         acc_ff   <= '0;
         sel_ff   <= '0;
         priority if (cmd.append && full) begin
            status_ff <= osrs_pkg::STATUS_FULL;
         end else if (cmd.sel_miss) begin
            status_ff <= osrs_pkg::STATUS_RANGE;
         end else begin
            status_ff <= osrs_pkg::STATUS_OK;
         end
      end
      if (cmd.rank_read) begin
         mid_ff <= mid_c;
      end
      if (cmd.rank_update) begin
         if (rd_ff < query_ff) begin
            acc_ff <= acc_ff + (mid_ff - lo_ff) + CW'(1);
            lo_ff  <= mid_ff + CW'(1);
         end else if (rd_ff == query_ff) begin
            acc_ff <= acc_ff + (mid_ff - lo_ff) + CW'(1);
         end else begin
            end_ff <= mid_ff;
         end
      end
      if (cmd.sel_latch) begin
         sel_ff <= rd_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status         <= status_ff;
         rsp_rank_count     <= 11'(acc_ff);
         rsp_selected_value <= sel_ff;
      end
   end

endmodule
`default_nettype wire

### rtl/order_statistic_rank_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// order_statistic_rank_select
// rank and select over a table of signed values appended in ascending
// order, searched along the implicit midpoint-balanced tree
// ----------------------------------------------------------------------------
// One request is worked at a time. Clear, append and an out-of-range select
// go straight from transfer to the done state; an in-range select first
// reads the table and latches the entry. Rank walks the tree one level at a
// time and stops on an equal entry or when the walk runs out, after at most
// ceil(log2(n+1)) levels for n stored entries; each level is one read of
// the table's single registered read port followed by one compare. A new
// request is taken as soon as the previous result sits in the output
// register, even if that result has not yet been transferred.
// The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module order_statistic_rank_select #(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [9:0]         req_position,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [1:0]         rsp_status,
   output      logic [10:0]        rsp_rank_count,
   output      logic signed [31:0] rsp_selected_value
);

   osrs_pkg::cmd_type cmd;
   osrs_pkg::sts_type sts;

   osrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   osrs_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_rank_count     (rsp_rank_count),
      .rsp_selected_value (rsp_selected_value)
   );

endmodule
`default_nettype wire
